FILE: rtl/hpt_pkg.sv
// Shared types and constants of the homography point transform.
// No dependencies; every other file of the block imports this package.
package hpt_pkg;

    localparam int COORD_W   = 16;              // Q12.4 coordinates
    localparam int COEF_W    = 24;              // Q8.16 coefficients
    localparam int SHIFT_W   = 32;              // Q16.16 translations
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int PROD_W    = COORD_W + COEF_W;     // 40
    localparam int SUM_W     = PROD_W + 2;           // 42, numerator and denominator
    localparam int NUM_W     = SUM_W + 4;            // 46, numerator times 16
    localparam int DIV_STEPS = COORD_W + 1;          // quotient magnitude bits
    localparam int CMP_W     = SUM_W + DIV_STEPS;    // 59, widest compare
    localparam int FRAC_ONE_SHIFT = 20;

    localparam logic [COEF_W-1:0]  RST_COEF_ONE = 24'd65536;
    localparam logic [COEF_W-1:0]  RST_COEF_ZERO = '0;
    localparam logic [SHIFT_W-1:0] RST_SHIFT = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_XX = 3'd0,
        REG_COEF_XY = 3'd1,
        REG_SHIFT_X = 3'd2,
        REG_COEF_YX = 3'd3,
        REG_COEF_YY = 3'd4,
        REG_SHIFT_Y = 3'd5,
        REG_PERSP_X = 3'd6,
        REG_PERSP_Y = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    // Control bits that travel with each request through the divider.
    typedef struct packed {
        logic valid;
        logic zero;
    } ctl_t;

endpackage

FILE: rtl/hpt_point_if.sv
// Input channel: one source point per request.
// Depends on hpt_pkg for the coordinate width.
interface hpt_point_if;
    import hpt_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    modport source (output valid, point_x, point_y, input ready);
    modport sink   (input valid, point_x, point_y, output ready);
endinterface

FILE: rtl/hpt_result_if.sv
// Output channel: one mapped point and its status per request.
// Depends on hpt_pkg for widths.
interface hpt_result_if;
    import hpt_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  mapped_x;
    logic signed [COORD_W-1:0]  mapped_y;
    logic [1:0]                 status;
    modport source (output valid, mapped_x, mapped_y, status, input ready);
    modport sink   (input valid, mapped_x, mapped_y, status, output ready);
endinterface

FILE: rtl/hpt_affine.sv
// Two-stage product and sum pipeline: numerators and denominator in Q.20.
// Depends on hpt_pkg.
module hpt_affine
    import hpt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic signed [COORD_W-1:0]  x,
    input  logic signed [COORD_W-1:0]  y,
    input  logic signed [COEF_W-1:0]   coef_xx,
    input  logic signed [COEF_W-1:0]   coef_xy,
    input  logic signed [SHIFT_W-1:0]  shift_x,
    input  logic signed [COEF_W-1:0]   coef_yx,
    input  logic signed [COEF_W-1:0]   coef_yy,
    input  logic signed [SHIFT_W-1:0]  shift_y,
    input  logic signed [COEF_W-1:0]   persp_x,
    input  logic signed [COEF_W-1:0]   persp_y,
    output logic                       out_valid,
    output logic signed [SUM_W-1:0]    num_x,
    output logic signed [SUM_W-1:0]    num_y,
    output logic signed [SUM_W-1:0]    den
);

    logic                      v1_reg, v2_reg;
    logic signed [PROD_W-1:0]  p_xx_reg, p_xy_reg, p_yx_reg, p_yy_reg, p_px_reg, p_py_reg;
    logic signed [SHIFT_W-1:0] tx_reg, ty_reg;
    logic signed [SUM_W-1:0]   nx_reg, ny_reg, den_reg;
    logic signed [SUM_W-1:0]   nx_next, ny_next, den_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_xx_reg <= PROD_W'(coef_xx * x);
            p_xy_reg <= PROD_W'(coef_xy * y);
            p_yx_reg <= PROD_W'(coef_yx * x);
            p_yy_reg <= PROD_W'(coef_yy * y);
            p_px_reg <= PROD_W'(persp_x * x);
            p_py_reg <= PROD_W'(persp_y * y);
            tx_reg   <= shift_x;
            ty_reg   <= shift_y;
            nx_reg   <= nx_next;
            ny_reg   <= ny_next;
            den_reg  <= den_next;
        end
    end

    always_comb
    begin
        nx_next  = SUM_W'(p_xx_reg) + SUM_W'(p_xy_reg) + (SUM_W'(tx_reg) <<< 4);
        ny_next  = SUM_W'(p_yx_reg) + SUM_W'(p_yy_reg) + (SUM_W'(ty_reg) <<< 4);
        den_next = SUM_W'(p_px_reg) + SUM_W'(p_py_reg)
                 + (SUM_W'(1) <<< FRAC_ONE_SHIFT);
    end

    assign out_valid = v2_reg;
    assign num_x     = nx_reg;
    assign num_y     = ny_reg;
    assign den       = den_reg;

endmodule

FILE: rtl/hpt_div.sv
// Pipelined restoring divider, one quotient bit per stage, x and y lanes
// sharing one divisor. Depends on hpt_pkg.
module hpt_div
    import hpt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic signed [SUM_W-1:0]    num_x,
    input  logic signed [SUM_W-1:0]    num_y,
    input  logic signed [SUM_W-1:0]    den,
    output ctl_t                       ctl_out,
    output logic [DIV_STEPS-1:0]       qmag_x,
    output logic [DIV_STEPS-1:0]       qmag_y,
    output logic                       neg_x,
    output logic                       neg_y,
    output logic                       ovf_x,
    output logic                       ovf_y
);

    ctl_t                 ctl_reg  [0:DIV_STEPS];
    logic [NUM_W-1:0]     rx_reg   [0:DIV_STEPS];
    logic [NUM_W-1:0]     ry_reg   [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] qx_reg   [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] qy_reg   [0:DIV_STEPS];
    logic [SUM_W-1:0]     d_reg    [0:DIV_STEPS];
    logic                 negx_reg [0:DIV_STEPS];
    logic                 negy_reg [0:DIV_STEPS];
    logic                 ovfx_reg [0:DIV_STEPS];
    logic                 ovfy_reg [0:DIV_STEPS];

    logic signed [NUM_W-1:0] nnx, nny;
    logic [NUM_W-1:0]        magx_next, magy_next;
    logic [SUM_W-1:0]        magd_next;
    logic [CMP_W-1:0]        dtop;
    ctl_t                    ctl_next;

    // Entry stage: sign and magnitude, zero divisor, overflow of the top bit.
    always_comb
    begin
        nnx       = NUM_W'(num_x) <<< 4;
        nny       = NUM_W'(num_y) <<< 4;
        magx_next = nnx[NUM_W-1] ? NUM_W'(-nnx) : NUM_W'(nnx);
        magy_next = nny[NUM_W-1] ? NUM_W'(-nny) : NUM_W'(nny);
        magd_next = den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
        dtop      = {magd_next, {DIV_STEPS{1'b0}}};
        ctl_next.valid = in_valid;
        ctl_next.zero  = (den == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else if (adv)
        begin
            ctl_reg[0] <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx_reg[0]   <= magx_next;
            ry_reg[0]   <= magy_next;
            d_reg[0]    <= magd_next;
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            negx_reg[0] <= num_x[SUM_W-1] ^ den[SUM_W-1];
            negy_reg[0] <= num_y[SUM_W-1] ^ den[SUM_W-1];
            ovfx_reg[0] <= CMP_W'(magx_next) >= dtop;
            ovfy_reg[0] <= CMP_W'(magy_next) >= dtop;
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_step
        localparam int B = DIV_STEPS - k;
        logic [CMP_W-1:0] dsh;
        logic             takex, takey;

        always_comb
        begin
            dsh   = CMP_W'(d_reg[k-1]) << B;
            takex = CMP_W'(rx_reg[k-1]) >= dsh;
            takey = CMP_W'(ry_reg[k-1]) >= dsh;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else if (adv)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rx_reg[k]    <= takex ? NUM_W'(CMP_W'(rx_reg[k-1]) - dsh) : rx_reg[k-1];
                ry_reg[k]    <= takey ? NUM_W'(CMP_W'(ry_reg[k-1]) - dsh) : ry_reg[k-1];
                qx_reg[k]    <= qx_reg[k-1] | (DIV_STEPS'(takex) << B);
                qy_reg[k]    <= qy_reg[k-1] | (DIV_STEPS'(takey) << B);
                d_reg[k]     <= d_reg[k-1];
                negx_reg[k]  <= negx_reg[k-1];
                negy_reg[k]  <= negy_reg[k-1];
                ovfx_reg[k]  <= ovfx_reg[k-1];
                ovfy_reg[k]  <= ovfy_reg[k-1];
            end
        end
    end

    assign ctl_out = ctl_reg[DIV_STEPS];
    assign qmag_x  = qx_reg[DIV_STEPS];
    assign qmag_y  = qy_reg[DIV_STEPS];
    assign neg_x   = negx_reg[DIV_STEPS];
    assign neg_y   = negy_reg[DIV_STEPS];
    assign ovf_x   = ovfx_reg[DIV_STEPS];
    assign ovf_y   = ovfy_reg[DIV_STEPS];

endmodule

FILE: rtl/homography_point_transform.sv
// Top level of the homography point transform: registers, pipeline, output stage.
// Depends on hpt_pkg, hpt_point_if, hpt_result_if, hpt_affine and hpt_div.
//
//  channel   dir   payload                          handshake
//  point     in    point_x, point_y                 valid / ready
//  mapped    out   mapped_x, mapped_y, status       valid / ready
//  cfg       in    cfg_index, cfg_data              cfg_we, no wait
//
// One point per clock while mapped is not stalled; the stages are two affine stages, one divider entry
// stage, 17 divider stages (one quotient bit each) and the output register.
// Reset clears valid bits and loads the identity matrix.
// A stall on mapped holds the whole pipeline; nothing is dropped or repeated.
module homography_point_transform
    import hpt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    hpt_point_if.sink              point,
    hpt_result_if.source           mapped,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DAT_W-1:0]   cfg_data
);

    logic signed [COEF_W-1:0]  coef_xx_reg, coef_xy_reg, coef_yx_reg, coef_yy_reg;
    logic signed [COEF_W-1:0]  persp_x_reg, persp_y_reg;
    logic signed [SHIFT_W-1:0] shift_x_reg, shift_y_reg;

    logic                    adv;
    logic                    aff_valid;
    logic signed [SUM_W-1:0] num_x, num_y, den;
    ctl_t                    dctl;
    logic [DIV_STEPS-1:0]    qmag_x, qmag_y;
    logic                    neg_x, neg_y, ovf_x, ovf_y;

    logic                      out_valid_reg;
    logic signed [COORD_W-1:0] out_x_reg, out_y_reg, out_x_next, out_y_next;
    status_t                   status_reg, status_next;
    logic                      sat_x, sat_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_xx_reg <= RST_COEF_ONE;
            coef_xy_reg <= RST_COEF_ZERO;
            shift_x_reg <= RST_SHIFT;
            coef_yx_reg <= RST_COEF_ZERO;
            coef_yy_reg <= RST_COEF_ONE;
            shift_y_reg <= RST_SHIFT;
            persp_x_reg <= RST_COEF_ZERO;
            persp_y_reg <= RST_COEF_ZERO;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_COEF_XX: coef_xx_reg <= cfg_data[COEF_W-1:0];
                REG_COEF_XY: coef_xy_reg <= cfg_data[COEF_W-1:0];
                REG_SHIFT_X: shift_x_reg <= cfg_data;
                REG_COEF_YX: coef_yx_reg <= cfg_data[COEF_W-1:0];
                REG_COEF_YY: coef_yy_reg <= cfg_data[COEF_W-1:0];
                REG_SHIFT_Y: shift_y_reg <= cfg_data;
                REG_PERSP_X: persp_x_reg <= cfg_data[COEF_W-1:0];
                REG_PERSP_Y: persp_y_reg <= cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance everything whenever the output register is free or being drained.
    assign adv         = !out_valid_reg || mapped.ready;
    assign point.ready = adv;

    hpt_affine u_affine (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (point.valid),
        .x         (point.point_x),
        .y         (point.point_y),
        .coef_xx   (coef_xx_reg),
        .coef_xy   (coef_xy_reg),
        .shift_x   (shift_x_reg),
        .coef_yx   (coef_yx_reg),
        .coef_yy   (coef_yy_reg),
        .shift_y   (shift_y_reg),
        .persp_x   (persp_x_reg),
        .persp_y   (persp_y_reg),
        .out_valid (aff_valid),
        .num_x     (num_x),
        .num_y     (num_y),
        .den       (den)
    );

    hpt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (aff_valid),
        .num_x    (num_x),
        .num_y    (num_y),
        .den      (den),
        .ctl_out  (dctl),
        .qmag_x   (qmag_x),
        .qmag_y   (qmag_y),
        .neg_x    (neg_x),
        .neg_y    (neg_y),
        .ovf_x    (ovf_x),
        .ovf_y    (ovf_y)
    );

    // Clamp: a negative quotient may reach magnitude 32768, a positive one 32767.
    always_comb
    begin
        sat_x = ovf_x || (neg_x ? (qmag_x > DIV_STEPS'(32768)) : qmag_x[COORD_W]
                                   || qmag_x[COORD_W-1]);
        sat_y = ovf_y || (neg_y ? (qmag_y > DIV_STEPS'(32768)) : qmag_y[COORD_W]
                                   || qmag_y[COORD_W-1]);
        if (sat_x)
            out_x_next = neg_x ? COORD_W'(-32768) : COORD_W'(32767);
        else
            out_x_next = neg_x ? COORD_W'(-qmag_x) : COORD_W'(qmag_x);
        if (sat_y)
            out_y_next = neg_y ? COORD_W'(-32768) : COORD_W'(32767);
        else
            out_y_next = neg_y ? COORD_W'(-qmag_y) : COORD_W'(qmag_y);
        status_next = (sat_x || sat_y) ? ST_SAT : ST_OK;
        if (dctl.zero)
        begin
            out_x_next  = '0;
            out_y_next  = '0;
            status_next = ST_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x_reg  <= out_x_next;
            out_y_reg  <= out_y_next;
            status_reg <= status_next;
        end
    end

    assign mapped.valid    = out_valid_reg;
    assign mapped.mapped_x = out_x_reg;
    assign mapped.mapped_y = out_y_reg;
    assign mapped.status   = status_reg;

    a_zero_outputs: assert property (@(posedge clk) disable iff (!rst_n)
        (mapped.valid && mapped.status == ST_ZERO) |-> (mapped.mapped_x == '0
            && mapped.mapped_y == '0))
        else $error("zero denominator result carries nonzero coordinates");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        mapped.valid |-> (mapped.status == ST_OK || mapped.status == ST_ZERO
            || mapped.status == ST_SAT))
        else $error("undefined status code on output");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (mapped.valid && !mapped.ready) |-> (!point.ready ##1 (mapped.valid
            && $stable(mapped.mapped_x) && $stable(mapped.mapped_y)
            && $stable(mapped.status))))
        else $error("pipeline moved while output stalled");

endmodule

FILE: tb/tb_hpt_channels.sv
`timescale 1ns / 1ps
// Testbench-side channel types: none needed beyond the RTL interfaces.
// Depends on hpt_pkg; holds the expected-result record shared by the bench.
package tb_hpt_types;
    import hpt_pkg::*;

    typedef struct {
        logic signed [COORD_W-1:0] mx;
        logic signed [COORD_W-1:0] my;
        status_t                   st;
    } mapped_pt_t;
endpackage

FILE: tb/tb_homography_point_transform.sv
`timescale 1ns / 1ps
// Testbench of homography_point_transform: random and corner points through
// several matrix settings, each result checked against a projective predictor.
// Depends on hpt_pkg, tb_hpt_types, the channel interfaces and the RTL.
module tb_homography_point_transform;
    import hpt_pkg::*;
    import tb_hpt_types::*;

    class mapped_scoreboard;
        mapped_pt_t pending[$];
        logic signed [COEF_W-1:0]  cxx, cxy, cyx, cyy, ppx, ppy;
        logic signed [SHIFT_W-1:0] tsx, tsy;
        int errors;

        function void set_reg(reg_idx_t idx, logic [CFG_DAT_W-1:0] d);
            case (idx)
                REG_COEF_XX: cxx = d[COEF_W-1:0];
                REG_COEF_XY: cxy = d[COEF_W-1:0];
                REG_SHIFT_X: tsx = d;
                REG_COEF_YX: cyx = d[COEF_W-1:0];
                REG_COEF_YY: cyy = d[COEF_W-1:0];
                REG_SHIFT_Y: tsy = d;
                REG_PERSP_X: ppx = d[COEF_W-1:0];
                REG_PERSP_Y: ppy = d[COEF_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clip(longint v, ref bit sat);
            if (v > 32767)
            begin
                sat = 1;
                return 32767;
            end
            if (v < -32768)
            begin
                sat = 1;
                return -32768;
            end
            return v;
        endfunction

        function void note_point(logic signed [COORD_W-1:0] x,
                                 logic signed [COORD_W-1:0] y);
            longint nx, ny, den;
            bit sat;
            mapped_pt_t e;
            sat = 0;
            nx = longint'(cxx) * x + longint'(cxy) * y + longint'(tsx) * 16;
            ny = longint'(cyx) * x + longint'(cyy) * y + longint'(tsy) * 16;
            den = longint'(ppx) * x + longint'(ppy) * y + (64'sd1 <<< FRAC_ONE_SHIFT);
            if (den == 0)
            begin
                e.mx = '0;
                e.my = '0;
                e.st = ST_ZERO;
            end
            else
            begin
                e.mx = COORD_W'(clip((nx * 16) / den, sat));
                e.my = COORD_W'(clip((ny * 16) / den, sat));
                e.st = sat ? ST_SAT : ST_OK;
            end
            pending.push_back(e);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic signed [COORD_W-1:0] mx,
                          logic signed [COORD_W-1:0] my, logic [1:0] st);
            mapped_pt_t e;
            if (pending.size() == 0)
            begin
                report("result with none expected");
                return;
            end
            e = pending.pop_front();
            if (mx !== e.mx)
                report($sformatf("mapped_x %0d exp %0d", mx, e.mx));
            if (my !== e.my)
                report($sformatf("mapped_y %0d exp %0d", my, e.my));
            if (st !== e.st)
                report($sformatf("status %0d exp %0d", st, e.st));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    bit long_hold;
    bit stall_en;

    hpt_point_if  point ();
    hpt_result_if mapped ();

    homography_point_transform u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .point     (point.sink),
        .mapped    (mapped.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mapped_scoreboard sb;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("tb_homography_point_transform: FAIL");
        $finish;
    end

    // Receiver: random stalls in phases, plus one long hold-off on request.
    initial
    begin
        mapped.ready = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
                mapped.ready <= 0;
            else if (stall_en)
                mapped.ready <= ($urandom_range(3, 0) != 0);
            else
                mapped.ready <= 1;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (mapped.valid && mapped.ready)
                sb.check_result(mapped.mapped_x, mapped.mapped_y, mapped.status);
        end
    end

    task write_reg(reg_idx_t idx, logic [CFG_DAT_W-1:0] d);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        sb.set_reg(idx, d);
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    // Offer one request and hold it until taken; keep valid high if burst continues.
    task send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                    bit more);
        point.valid <= 1;
        point.point_x <= x;
        point.point_y <= y;
        do
            @(posedge clk);
        while (!point.ready);
        sb.note_point(x, y);
        if (!more)
            point.valid <= 0;
    endtask

    task send_burst(int n, bit full_range);
        int k;
        int burst;
        logic signed [COORD_W-1:0] x, y;
        k = 0;
        while (k < n)
        begin
            burst = $urandom_range(12, 1);
            for (int j = 0; j < burst && k < n; j++)
            begin
                if (full_range || $urandom_range(3, 0) == 0)
                begin
                    x = COORD_W'($urandom);
                    y = COORD_W'($urandom);
                end
                else
                begin
                    x = COORD_W'($urandom_range(1024, 0) - 512);
                    y = COORD_W'($urandom_range(1024, 0) - 512);
                end
                k++;
                send_point(x, y, (j + 1 < burst) && (k < n));
            end
            // Wait with valid low before the next burst.
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    task drain;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task random_matrix(bit mild);
        logic [CFG_DAT_W-1:0] d;
        for (int r = REG_COEF_XX; r <= REG_PERSP_Y; r++)
        begin
            d = $urandom;
            if (mild && r != REG_SHIFT_X && r != REG_SHIFT_Y)
                d = {{14{d[17]}}, d[17:0]};
            if (mild && (r == REG_PERSP_X || r == REG_PERSP_Y))
                d = {{20{d[11]}}, d[11:0]};
            write_reg(reg_idx_t'(r), d);
        end
    endtask

    initial
    begin
        sb = new();
        sb.cxx = RST_COEF_ONE;
        sb.cxy = RST_COEF_ZERO;
        sb.cyx = RST_COEF_ZERO;
        sb.cyy = RST_COEF_ONE;
        sb.ppx = RST_COEF_ZERO;
        sb.ppy = RST_COEF_ZERO;
        sb.tsx = RST_SHIFT;
        sb.tsy = RST_SHIFT;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = REG_COEF_XX;
        cfg_data = '0;
        point.valid = 0;
        point.point_x = '0;
        point.point_y = '0;
        long_hold = 0;
        stall_en = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Identity: extremes of both fields pass through unchanged.
        send_point(16'sh7fff, 16'sh8000, 1);
        send_point(16'sh8000, 16'sh7fff, 1);
        send_point(0, 0, 1);
        send_point(-1, 1, 0);
        drain();

        // Scale x by 2 and y by -2 to force saturation, add translation extremes.
        write_reg(REG_COEF_XX, 32'h020000);
        write_reg(REG_COEF_YY, 32'hfe0000);
        write_reg(REG_SHIFT_X, 32'h7fffffff);
        write_reg(REG_SHIFT_Y, 32'h80000000);
        send_point(16'sh7fff, 16'sh7fff, 1);
        send_point(16'sh8000, 16'sh8000, 1);
        send_point(16, -16, 0);
        drain();

        // Zero denominator: persp_x = -1.0 with x = 1.0 gives s = 0.
        write_reg(REG_SHIFT_X, 32'h00010000);
        write_reg(REG_SHIFT_Y, 32'hffff0000);
        write_reg(REG_PERSP_X, 32'hff0000);
        write_reg(REG_PERSP_Y, 32'h800000);
        send_point(16, 0, 1);
        send_point(8, 0, 1);
        send_point(-16, 0, 1);
        send_point(0, 1, 1);
        send_point(32, 0, 0);
        drain();
        write_reg(REG_PERSP_Y, 32'h7fffff);
        write_reg(REG_COEF_XY, 32'h7fffff);
        write_reg(REG_COEF_YX, 32'h800000);
        send_point(16'sh7fff, 16'sh8000, 1);
        send_point(-1, -1, 0);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            random_matrix(ph % 3 != 2);
            stall_en = ph[0];
            if (ph == 3)
            begin
                fork
                    send_burst(60, 0);
                    begin
                        long_hold = 1;
                        repeat (200) @(posedge clk);
                        long_hold = 0;
                    end
                join
            end
            else
                send_burst(60, ph == 7);
            drain();
        end

        if (sb.errors == 0)
            $display("tb_homography_point_transform: PASS");
        else
            $display("tb_homography_point_transform: FAIL");
        $finish;
    end
endmodule
